@@ rtl/rfma_pkg.sv @@
// Package for the rectangle fill / move address generator.
// Types, codes and widths shared by every rtl file but rfma_if. No dependencies.
`default_nettype none
package rfma_pkg;
    localparam int MAX_SIDE = 4096;
    localparam int CW = $clog2(MAX_SIDE) + 1;   // coordinate width
    localparam int SW = CW + 1;                 // offset width

    typedef enum logic [1:0] {
        CMD_FILL = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_STEP = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    localparam logic [2:0] KIND_IDLE = 3'd0;
    localparam logic [2:0] KIND_ACC  = 3'd1;
    localparam logic [2:0] KIND_REJ  = 3'd2;
    localparam logic [2:0] KIND_FILL = 3'd3;
    localparam logic [2:0] KIND_COPY = 3'd4;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_LINE   = 3'd2;
    localparam logic [2:0] REG_FOUR   = 3'd3;
    localparam logic [2:0] REG_BASE   = 3'd4;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               whole_raster;
        logic signed [15:0] rect_left;
        logic signed [15:0] rect_top;
        logic signed [15:0] rect_right;
        logic signed [15:0] rect_bottom;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic [31:0]        fill_color;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [31:0] color;
        logic        last;
    } t_out;

    // Classified request handed from front to back.
    typedef struct packed {
        logic [1:0]    op;      // 0 idle, 1 start, 2 reject, 3 step
        logic          moving;
        logic          x_backward;
        logic          y_backward;
        logic [CW-1:0] x_first;
        logic [CW-1:0] x_end;
        logic [CW-1:0] y_first;
        logic [CW-1:0] y_end;
        logic [SW-1:0] src_off_x;
        logic [SW-1:0] src_off_y;
        logic [31:0]   color;
    } t_job;

    localparam logic [1:0] OP_IDLE  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_REJ   = 2'd2;
    localparam logic [1:0] OP_STEP  = 2'd3;
endpackage
`default_nettype wire

@@ rtl/rfma_if.sv @@
// Valid/ready channel carrying one payload.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface rfma_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/rfma_front.sv @@
// Front: accepts requests, clips commands against the raster, registers the job.
// Depends on rfma_pkg.
`default_nettype none
module rfma_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rfma_pkg::t_in        i_req,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [12:0]          i_raster_width,
    input  wire logic [12:0]          i_raster_height,
    output rfma_pkg::t_job            o_job,
    output logic                      o_job_valid,
    input  wire logic                 i_job_ready
);
    import rfma_pkg::*;

    logic signed [17:0] w, h, l, t, r, b, mx, my, cl, ct, cr, cb;
    logic          rej;
    t_job          job;
    t_job          r_job;
    logic          r_vld;

    always_comb begin
        w = (i_raster_width > 13'(MAX_SIDE)) ? 18'(MAX_SIDE) : 18'(i_raster_width);
        h = (i_raster_height > 13'(MAX_SIDE)) ? 18'(MAX_SIDE) : 18'(i_raster_height);
        mx = 18'(i_req.move_x);
        my = 18'(i_req.move_y);
        rej = 1'b0;
        if (i_req.whole_raster) begin
            l = '0; t = '0; r = w; b = h;
        end else begin
            l = 18'(i_req.rect_left); t = 18'(i_req.rect_top);
            r = 18'(i_req.rect_right); b = 18'(i_req.rect_bottom);
            if (r <= l || b <= t) rej = 1'b1;
        end
        if (w == 0 || h == 0) rej = 1'b1;
        if (i_req.cmd == CMD_MOVE) begin
            if (mx == 0 && my == 0) rej = 1'b1;
            if (l < 0 || t < 0 || r > w || b > h) rej = 1'b1;
            l = l + mx; r = r + mx; t = t + my; b = b + my;
        end
        cl = (l > 0) ? l : '0;
        ct = (t > 0) ? t : '0;
        cr = (r < w) ? r : w;
        cb = (b < h) ? b : h;
        if (cr <= cl || cb <= ct) rej = 1'b1;

        job = '0;
        job.moving = (i_req.cmd == CMD_MOVE);
        if (job.moving) begin
            job.y_backward = my > 0;
            job.x_backward = (my == 0) && (mx > 0);
            job.src_off_x  = SW'(-mx);
            job.src_off_y  = SW'(-my);
        end else begin
            job.color = i_req.fill_color;
        end
        if (job.x_backward) begin
            job.x_first = CW'(cr - 1); job.x_end = CW'(cl);
        end else begin
            job.x_first = CW'(cl); job.x_end = CW'(cr - 1);
        end
        if (job.y_backward) begin
            job.y_first = CW'(cb - 1); job.y_end = CW'(ct);
        end else begin
            job.y_first = CW'(ct); job.y_end = CW'(cb - 1);
        end
        case (i_req.cmd)
            CMD_FILL, CMD_MOVE: job.op = rej ? OP_REJ : OP_START;
            CMD_STEP:           job.op = OP_STEP;
            default:            job.op = OP_IDLE;
        endcase
    end

    assign o_ready     = !r_vld || i_job_ready;
    assign o_job       = r_job;
    assign o_job_valid = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) r_job <= job;
    end
endmodule
`default_nettype wire

@@ rtl/rfma_queue.sv @@
// Two-entry queue between front and back.
// Depends on rfma_pkg.
`default_nettype none
module rfma_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rfma_pkg::t_job i_job,
    input  wire logic           i_valid,
    output logic                o_ready,
    output rfma_pkg::t_job      o_job,
    output logic                o_valid,
    input  wire logic           i_ready
);
    import rfma_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) r_mem[r_wp] <= i_job;
    end
endmodule
`default_nettype wire

@@ rtl/rfma_back.sv @@
// Back: walks the clipped area and forms byte addresses, one pixel per step request.
// Depends on rfma_pkg.
`default_nettype none
module rfma_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rfma_pkg::t_job i_job,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [14:0]    i_line_bytes,
    input  wire logic           i_four,
    input  wire logic [31:0]    i_base,
    output rfma_pkg::t_out      o_res,
    output logic                o_valid,
    input  wire logic           i_res_ready
);
    import rfma_pkg::*;

    logic          r_busy, r_moving, r_xb, r_yb;
    logic [CW-1:0] r_cx, r_cy, r_xf, r_xe, r_ye;
    logic [SW-1:0] r_ox, r_oy;
    logic [31:0]   r_col;
    t_out          r_res;
    logic          r_ovld;

    logic          take, row_done, all_done;
    logic [31:0]   sx, sy, dst, src;
    t_out          res;

    assign o_ready = !r_ovld || i_res_ready;
    assign take    = o_ready && i_valid;
    assign row_done = r_cx == r_xe;
    assign all_done = row_done && (r_cy == r_ye);

    always_comb begin
        sx  = 32'(r_cx) + {{(32-SW){r_ox[SW-1]}}, r_ox};
        sy  = 32'(r_cy) + {{(32-SW){r_oy[SW-1]}}, r_oy};
        dst = i_base + 32'(r_cy) * 32'(i_line_bytes) + (32'(r_cx) << (i_four ? 2 : 1));
        src = i_base + sy * 32'(i_line_bytes) + (sx << (i_four ? 2 : 1));
        res = '0;
        case (i_job.op)
            OP_START: res.kind = KIND_ACC;
            OP_REJ:   res.kind = KIND_REJ;
            OP_STEP: begin
                if (r_busy) begin
                    res.dst_address = dst;
                    res.last = all_done;
                    if (r_moving) begin
                        res.kind = KIND_COPY;
                        res.src_address = src;
                    end else begin
                        res.kind  = KIND_FILL;
                        res.color = i_four ? r_col : {16'd0, r_col[15:0]};
                    end
                end
            end
            default: res.kind = KIND_IDLE;
        endcase
    end

    assign o_res   = r_res;
    assign o_valid = r_ovld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            if (o_ready) r_ovld <= i_valid;
            if (take) begin
                case (i_job.op)
                    OP_START: r_busy <= 1'b1;
                    OP_REJ:   r_busy <= 1'b0;
                    OP_STEP:  if (r_busy && all_done) r_busy <= 1'b0;
                    default: ;
                endcase
            end
        end
        if (take) begin
            r_res <= res;
            if (i_job.op == OP_START) begin
                r_moving <= i_job.moving; r_xb <= i_job.x_backward;
                r_yb <= i_job.y_backward; r_xf <= i_job.x_first;
                r_xe <= i_job.x_end; r_ye <= i_job.y_end;
                r_cx <= i_job.x_first; r_cy <= i_job.y_first;
                r_ox <= i_job.src_off_x; r_oy <= i_job.src_off_y;
                r_col <= i_job.color;
            end else if (i_job.op == OP_STEP && r_busy && !all_done) begin
                if (row_done) begin
                    r_cx <= r_xf;
                    r_cy <= r_yb ? r_cy - 1'b1 : r_cy + 1'b1;
                end else begin
                    r_cx <= r_xb ? r_cx - 1'b1 : r_cx + 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/rect_fill_move_address_generator.sv @@
// channel | dir | payload
// s_in    | in  | t_in  (cmd, rectangle, move, colour)
// m_out   | out | t_out (kind, addresses, colour, last)
// One request per cycle sustained while the output does not stall; a request passes the front
// register, the queue and the back output register. Synchronous active-low reset clears all
// control; stalls on the output propagate back through the queue.
// Depends on rfma_pkg, rfma_if, rfma_front, rfma_queue, rfma_back.
`default_nettype none
module rect_fill_move_address_generator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rfma_if.sink             s_in,
    rfma_if.source           m_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import rfma_pkg::*;

    logic [12:0] r_w, r_h;
    logic [14:0] r_lb;
    logic        r_four;
    logic [31:0] r_base;
    t_job        f_job, q_job;
    logic        f_vld, f_rdy, q_vld, q_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 13'd640; r_h <= 13'd480; r_lb <= 15'd1280;
            r_four <= 1'b0; r_base <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_w <= i_cfg_data[12:0];
                REG_HEIGHT: r_h <= i_cfg_data[12:0];
                REG_LINE:   r_lb <= i_cfg_data[14:0];
                REG_FOUR:   r_four <= i_cfg_data[0];
                REG_BASE:   r_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rfma_front u_front (
        .i_clk, .i_rst_n, .i_req(s_in.data), .i_valid(s_in.valid), .o_ready(s_in.ready),
        .i_raster_width(r_w), .i_raster_height(r_h),
        .o_job(f_job), .o_job_valid(f_vld), .i_job_ready(f_rdy)
    );

    rfma_queue u_queue (
        .i_clk, .i_rst_n, .i_job(f_job), .i_valid(f_vld), .o_ready(f_rdy),
        .o_job(q_job), .o_valid(q_vld), .i_ready(q_rdy)
    );

    rfma_back u_back (
        .i_clk, .i_rst_n, .i_job(q_job), .i_valid(q_vld), .o_ready(q_rdy),
        .i_line_bytes(r_lb), .i_four(r_four), .i_base(r_base),
        .o_res(m_out.data), .o_valid(m_out.valid), .i_res_ready(m_out.ready)
    );
endmodule
`default_nettype wire

@@ rtl/rfma_checker.sv @@
// Port-level checks for the address generator, bound to the top level.
// Depends on rfma_pkg.
`default_nettype none
module rfma_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire rfma_pkg::t_out out_data
);
    import rfma_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped under stall");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data.kind <= KIND_COPY)
        else $error("bad kind");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.last |-> out_data.kind == KIND_FILL
            || out_data.kind == KIND_COPY)
        else $error("last on non-pixel result");
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.kind != KIND_COPY |-> out_data.src_address == '0)
        else $error("source address on non-copy");
endmodule

bind rect_fill_move_address_generator rfma_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .out_valid(m_out.valid),
    .out_ready(m_out.ready), .out_data(m_out.data)
);
`default_nettype wire
